### rtl/pcv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcv_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
    } pcv_item_t;

    typedef enum logic [1:0] {
        VERDICT_MATCH    = 2'd0,
        VERDICT_MISMATCH = 2'd1,
        VERDICT_CRC_BAD  = 2'd2,
        VERDICT_DATA_BAD = 2'd3
    } verdict_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
    } pcv_result_t;

    localparam int KEY_MAX      = 7;
    localparam int CRC_KEY_LEN  = 6;
    localparam int DATA_KEY_LEN = 7;

    // "CRC":  index 0 in the low byte
    localparam logic [KEY_MAX-1:0][7:0] CRC_KEY =
        {8'h00, 8'h3A, 8'h22, 8'h43, 8'h52, 8'h43, 8'h22};
    // "DATA":
    localparam logic [KEY_MAX-1:0][7:0] DATA_KEY =
        {8'h3A, 8'h22, 8'h41, 8'h54, 8'h41, 8'h44, 8'h22};

    localparam logic [7:0]  CH_QUOTE   = 8'h22;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  CH_LBRACE  = 8'h7B;
    localparam logic [7:0]  CH_RBRACE  = 8'h7D;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Longest key prefix that is a suffix of the matched prefix plus c.
    function automatic logic [2:0] key_advance(
        input logic [KEY_MAX-1:0][7:0] key,
        input int                      klen,
        input logic [2:0]              k_in,
        input logic [7:0]              c
    );
        int         k;
        int         i;
        int         j;
        logic       ok;
        logic       found;
        logic [2:0] res;
        k = int'(k_in);
        if (k >= klen)
        begin
            k = klen - 1;
        end
        res   = 3'd0;
        found = 1'b0;
        for (j = KEY_MAX; j >= 1; j--)
        begin
            if (!found && j <= k + 1)
            begin
                ok = (key[j-1] == c);
                for (i = 0; i < KEY_MAX - 1; i++)
                begin
                    if (i < j - 1)
                    begin
                        if (key[i] != key[k-j+1+i])
                        begin
                            ok = 1'b0;
                        end
                    end
                end
                if (ok)
                begin
                    res   = 3'(j);
                    found = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // {is_hex, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else
        begin
            r = 5'd0;
        end
        return r;
    endfunction

    // Modbus CRC-16, one byte, bitwise
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] crc;
        int          n;
        crc = crc_in ^ {8'h00, b};
        for (n = 0; n < 8; n++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

### rtl/payload_crc_verifier.sv
// A last beat goes to the input register, then its verdict to the result register.
// Throughput: one beat per cycle while input is not stalled; the per-byte CRC update
// and both key matchers are combinational between the input and result registers.
// A waiting result stalls input only when the registered beat is a last beat.
// Reset (rst_n low, async): both parsers return to key search, CRC to 0xFFFF,
// no beat or result held. Parser state also returns to reset after each last beat.
`timescale 1ns / 1ps
`default_nettype none

module payload_crc_verifier #(
    parameter int MAX_OBJECT_LEN = 512
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire pcv_pkg::pcv_item_t  item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output pcv_pkg::pcv_result_t     result
);
    import pcv_pkg::*;

    localparam int LEN_W = $clog2(MAX_OBJECT_LEN);

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_LEAD   = 3'd1,
        PH_BODY   = 3'd2,
        PH_DONE   = 3'd3,
        PH_FAIL   = 3'd4
    } phase_t;

    logic              s1_valid_reg, s1_valid_next;
    logic [7:0]        s1_byte_reg;
    logic              s1_last_reg;
    logic              s1_go;

    phase_t            crc_phase_reg, crc_phase_next;
    logic [2:0]        crc_pos_reg, crc_pos_next;
    logic [2:0]        crc_count_reg, crc_count_next;
    logic [15:0]       crc_hex_reg, crc_hex_next;
    logic              hex_open_reg, hex_open_next;

    phase_t            data_phase_reg, data_phase_next;
    logic [2:0]        data_pos_reg, data_pos_next;
    logic [LEN_W-1:0]  depth_reg, depth_next;
    logic [LEN_W-1:0]  obj_len_reg, obj_len_next;
    logic [15:0]       run_crc_reg, run_crc_next;

    logic              result_valid_reg, result_valid_next;
    pcv_result_t       result_reg, result_next;

    logic [2:0]        crc_match;
    logic [2:0]        data_match;
    logic [4:0]        hex_dec;
    logic              body_active;
    logic [LEN_W-1:0]  len_cur;
    logic [LEN_W-1:0]  depth_cur;
    logic [LEN_W:0]    len_plus;

    assign s1_go        = s1_valid_reg && (!s1_last_reg || !result_valid_reg || result_ready);
    assign item_ready   = !s1_valid_reg || s1_go;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign crc_match  = key_advance(CRC_KEY, CRC_KEY_LEN, crc_pos_reg, s1_byte_reg);
    assign data_match = key_advance(DATA_KEY, DATA_KEY_LEN, data_pos_reg, s1_byte_reg);
    assign hex_dec    = hex_decode(s1_byte_reg);

    always_comb
    begin
        s1_valid_next     = s1_valid_reg;
        crc_phase_next    = crc_phase_reg;
        crc_pos_next      = crc_pos_reg;
        crc_count_next    = crc_count_reg;
        crc_hex_next      = crc_hex_reg;
        hex_open_next     = hex_open_reg;
        data_phase_next   = data_phase_reg;
        data_pos_next     = data_pos_reg;
        depth_next        = depth_reg;
        obj_len_next      = obj_len_reg;
        run_crc_next      = run_crc_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        body_active       = 1'b0;
        len_cur           = obj_len_reg;
        depth_cur         = depth_reg;
        len_plus          = '0;

        if (item_ready)
        begin
            s1_valid_next = item_valid;
        end

        if (s1_go)
        begin
            case (crc_phase_reg)
                PH_SEARCH:
                begin
                    if (int'(crc_match) >= CRC_KEY_LEN)
                    begin
                        crc_pos_next   = 3'd0;
                        crc_phase_next = PH_LEAD;
                    end
                    else
                    begin
                        crc_pos_next = crc_match;
                    end
                end
                PH_LEAD:
                begin
                    if (s1_byte_reg != CH_SPACE)
                    begin
                        crc_phase_next = (s1_byte_reg == CH_QUOTE) ? PH_BODY : PH_FAIL;
                    end
                end
                PH_BODY:
                begin
                    if (s1_byte_reg == CH_QUOTE)
                    begin
                        crc_phase_next = (crc_count_reg == 3'd0) ? PH_FAIL : PH_DONE;
                    end
                    else if (crc_count_reg == 3'd7)
                    begin
                        crc_phase_next = PH_FAIL;
                    end
                    else
                    begin
                        crc_count_next = crc_count_reg + 3'd1;
                        if (hex_open_reg && hex_dec[4])
                        begin
                            crc_hex_next = {crc_hex_reg[11:0], hex_dec[3:0]};
                        end
                        else
                        begin
                            hex_open_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            case (data_phase_reg)
                PH_SEARCH:
                begin
                    if (int'(data_match) >= DATA_KEY_LEN)
                    begin
                        data_pos_next   = 3'd0;
                        data_phase_next = PH_LEAD;
                    end
                    else
                    begin
                        data_pos_next = data_match;
                    end
                end
                PH_LEAD:
                begin
                    if (s1_byte_reg == CH_LBRACE)
                    begin
                        body_active = 1'b1;
                        len_cur     = '0;
                        depth_cur   = '0;
                    end
                    else if (s1_byte_reg != CH_SPACE)
                    begin
                        data_phase_next = PH_FAIL;
                    end
                end
                PH_BODY:
                begin
                    body_active = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (body_active)
            begin
                len_plus = {1'b0, len_cur} + 1'b1;
                if (int'(len_plus) >= MAX_OBJECT_LEN)
                begin
                    data_phase_next = PH_FAIL;
                    obj_len_next    = len_cur;
                    depth_next      = depth_cur;
                end
                else
                begin
                    data_phase_next = PH_BODY;
                    obj_len_next    = len_plus[LEN_W-1:0];
                    run_crc_next    = crc16_byte(run_crc_reg, s1_byte_reg);
                    depth_next      = depth_cur;
                    if (s1_byte_reg == CH_LBRACE)
                    begin
                        depth_next = depth_cur + 1'b1;
                    end
                    else if (s1_byte_reg == CH_RBRACE)
                    begin
                        if (depth_cur != '0)
                        begin
                            depth_next = depth_cur - 1'b1;
                        end
                        if (depth_cur <= LEN_W'(1))
                        begin
                            data_phase_next = PH_DONE;
                        end
                    end
                end
            end

            if (s1_last_reg)
            begin
                result_valid_next         = 1'b1;
                result_next.computed_crc  = 16'h0000;
                result_next.received_crc  = 16'h0000;
                if (crc_phase_next != PH_DONE)
                begin
                    result_next.verdict = VERDICT_CRC_BAD;
                end
                else if (data_phase_next != PH_DONE)
                begin
                    result_next.verdict      = VERDICT_DATA_BAD;
                    result_next.received_crc = crc_hex_next;
                end
                else
                begin
                    result_next.received_crc = crc_hex_next;
                    result_next.computed_crc = run_crc_next;
                    result_next.verdict      = (run_crc_next == crc_hex_next) ?
                                               VERDICT_MATCH : VERDICT_MISMATCH;
                end

                crc_phase_next  = PH_SEARCH;
                crc_pos_next    = 3'd0;
                crc_count_next  = 3'd0;
                crc_hex_next    = 16'h0000;
                hex_open_next   = 1'b1;
                data_phase_next = PH_SEARCH;
                data_pos_next   = 3'd0;
                depth_next      = '0;
                obj_len_next    = '0;
                run_crc_next    = CRC_INIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            crc_phase_reg    <= PH_SEARCH;
            crc_pos_reg      <= 3'd0;
            crc_count_reg    <= 3'd0;
            crc_hex_reg      <= 16'h0000;
            hex_open_reg     <= 1'b1;
            data_phase_reg   <= PH_SEARCH;
            data_pos_reg     <= 3'd0;
            depth_reg        <= '0;
            obj_len_reg      <= '0;
            run_crc_reg      <= CRC_INIT;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            crc_phase_reg    <= crc_phase_next;
            crc_pos_reg      <= crc_pos_next;
            crc_count_reg    <= crc_count_next;
            crc_hex_reg      <= crc_hex_next;
            hex_open_reg     <= hex_open_next;
            data_phase_reg   <= data_phase_next;
            data_pos_reg     <= data_pos_next;
            depth_reg        <= depth_next;
            obj_len_reg      <= obj_len_next;
            run_crc_reg      <= run_crc_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            s1_byte_reg <= item.text_byte;
            s1_last_reg <= item.is_last;
        end
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

### rtl/pcv_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pcv_checker (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    input  wire logic                  item_ready,
    input  wire pcv_pkg::pcv_item_t    item,
    input  wire logic                  result_valid,
    input  wire logic                  result_ready,
    input  wire pcv_pkg::pcv_result_t  result
);
    import pcv_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat dropped or changed while stalled");

    a_crc_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.verdict == VERDICT_CRC_BAD |->
        result.computed_crc == 16'h0000 && result.received_crc == 16'h0000)
        else $error("crc field bad but crc values nonzero");

    a_data_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.verdict == VERDICT_DATA_BAD |->
        result.computed_crc == 16'h0000)
        else $error("data object bad but computed crc nonzero");

    a_verdict_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.verdict == VERDICT_MATCH ||
                         result.verdict == VERDICT_MISMATCH) |->
        ((result.computed_crc == result.received_crc) ==
         (result.verdict == VERDICT_MATCH)))
        else $error("match verdict disagrees with crc values");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready && item.is_last, 2) ||
                                $past(result_valid && result_ready) ||
                                $past(!item_ready))
        else $error("result appeared without a last beat before it");

endmodule

bind payload_crc_verifier pcv_checker u_pcv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import pcv_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int OBJ_MAX       = 512;
    localparam int TOTAL_BEATS   = 1950;
    localparam int CALM_BEATS    = 150;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [7:0]  ASCII_QUOTE  = 8'h22;
    localparam logic [7:0]  ASCII_SPACE  = 8'h20;
    localparam logic [7:0]  ASCII_LBRACE = 8'h7B;
    localparam logic [7:0]  ASCII_RBRACE = 8'h7D;
    localparam logic [7:0]  ASCII_TILDE  = 8'h7E;
    localparam logic [15:0] MODBUS_SEED  = 16'hFFFF;
    localparam logic [15:0] MODBUS_POLY  = 16'hA001;

    typedef enum logic [2:0] {
        FLD_SEARCH,
        FLD_LEAD,
        FLD_BODY,
        FLD_DONE,
        FLD_FAIL
    } field_phase_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    pcv_item_t   item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    pcv_result_t result;

    string crc_tag  = "\"CRC\":";
    string data_tag = "\"DATA\":";

    field_phase_t crc_phase;
    field_phase_t obj_phase;
    logic [2:0]   crc_tag_pos;
    logic [2:0]   data_tag_pos;
    logic [2:0]   crc_chars;
    logic [15:0]  crc_digits;
    logic         digits_open;
    logic [9:0]   obj_depth;
    logic [9:0]   obj_len;
    logic [15:0]  obj_crc;

    pcv_result_t pending_verdicts[$];
    pcv_result_t want_result;
    logic [7:0]  payload_bytes[$];
    logic [7:0]  object_bytes[$];

    bit bursty      = 1'b1;
    int beats_sent  = 0;
    int fail_count  = 0;
    int cycle_count = 0;

    payload_crc_verifier #(
        .MAX_OBJECT_LEN(OBJ_MAX)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [15:0] modbus_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        int          n;
        r = acc ^ {8'h00, b};
        for (n = 0; n < 8; n++)
        begin
            r = r[0] ? ((r >> 1) ^ MODBUS_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // longest tag prefix that ends the matched text plus c
    function automatic logic [2:0] next_key_pos(input string tag, input int pos,
                                                input logic [7:0] c);
        int   k;
        int   j;
        int   i;
        logic hit;
        k = (pos >= tag.len()) ? tag.len() - 1 : pos;
        for (j = k + 1; j >= 1; j--)
        begin
            hit = (tag[j-1] == c);
            for (i = 0; i < j - 1; i++)
            begin
                if (tag[i] != tag[k-j+1+i])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                return 3'(j);
            end
        end
        return 3'd0;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return c - "0";
        end
        if (c >= "a" && c <= "f")
        begin
            return c - "a" + 10;
        end
        if (c >= "A" && c <= "F")
        begin
            return c - "A" + 10;
        end
        return -1;
    endfunction

    function automatic void clear_parser();
        crc_phase    = FLD_SEARCH;
        obj_phase    = FLD_SEARCH;
        crc_tag_pos  = '0;
        data_tag_pos = '0;
        crc_chars    = '0;
        crc_digits   = '0;
        digits_open  = 1'b1;
        obj_depth    = '0;
        obj_len      = '0;
        obj_crc      = MODBUS_SEED;
    endfunction

    function automatic void parse_beat(input logic [7:0] c, input logic last);
        logic [2:0]  pos;
        int          nib;
        logic        take;
        pcv_result_t want;
        take = 1'b0;

        case (crc_phase)
            FLD_SEARCH:
            begin
                pos = next_key_pos(crc_tag, crc_tag_pos, c);
                if (pos == crc_tag.len())
                begin
                    crc_tag_pos = '0;
                    crc_phase   = FLD_LEAD;
                end
                else
                begin
                    crc_tag_pos = pos;
                end
            end
            FLD_LEAD:
            begin
                if (c != ASCII_SPACE)
                begin
                    crc_phase = (c == ASCII_QUOTE) ? FLD_BODY : FLD_FAIL;
                end
            end
            FLD_BODY:
            begin
                if (c == ASCII_QUOTE)
                begin
                    crc_phase = (crc_chars == 0) ? FLD_FAIL : FLD_DONE;
                end
                else if (crc_chars >= 7)
                begin
                    crc_phase = FLD_FAIL;
                end
                else
                begin
                    crc_chars++;
                    nib = hex_nibble(c);
                    if (digits_open && nib >= 0)
                    begin
                        crc_digits = {crc_digits[11:0], 4'(nib)};
                    end
                    else
                    begin
                        digits_open = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        case (obj_phase)
            FLD_SEARCH:
            begin
                pos = next_key_pos(data_tag, data_tag_pos, c);
                if (pos == data_tag.len())
                begin
                    data_tag_pos = '0;
                    obj_phase    = FLD_LEAD;
                end
                else
                begin
                    data_tag_pos = pos;
                end
            end
            FLD_LEAD:
            begin
                if (c != ASCII_SPACE)
                begin
                    if (c != ASCII_LBRACE)
                    begin
                        obj_phase = FLD_FAIL;
                    end
                    else
                    begin
                        obj_phase = FLD_BODY;
                        obj_depth = '0;
                        obj_len   = '0;
                        take      = 1'b1;
                    end
                end
            end
            FLD_BODY:
            begin
                take = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (take)
        begin
            if (obj_len + 1 >= OBJ_MAX)
            begin
                obj_phase = FLD_FAIL;
            end
            else
            begin
                obj_len++;
                obj_crc = modbus_update(obj_crc, c);
                if (c == ASCII_LBRACE)
                begin
                    obj_depth++;
                end
                else if (c == ASCII_RBRACE)
                begin
                    if (obj_depth > 0)
                    begin
                        obj_depth--;
                    end
                    if (obj_depth == 0)
                    begin
                        obj_phase = FLD_DONE;
                    end
                end
            end
        end

        if (last)
        begin
            want = '0;
            if (crc_phase != FLD_DONE)
            begin
                want.verdict = VERDICT_CRC_BAD;
            end
            else if (obj_phase != FLD_DONE)
            begin
                want.verdict      = VERDICT_DATA_BAD;
                want.received_crc = crc_digits;
            end
            else
            begin
                want.received_crc = crc_digits;
                want.computed_crc = obj_crc;
                if (obj_crc == crc_digits)
                begin
                    want.verdict = VERDICT_MATCH;
                end
                else
                begin
                    want.verdict = VERDICT_MISMATCH;
                end
            end
            pending_verdicts.push_back(want);
            clear_parser();
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
        begin
            parse_beat(item.text_byte, item.is_last);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result verdict %0d computed %h received %h",
                         $time, result.verdict, result.computed_crc, result.received_crc);
                fail_count++;
            end
            else
            begin
                want_result = pending_verdicts.pop_front();
                if (result.verdict !== want_result.verdict)
                begin
                    $display("%0t: verdict expected %0d actual %0d",
                             $time, want_result.verdict, result.verdict);
                    fail_count++;
                end
                if (result.computed_crc !== want_result.computed_crc)
                begin
                    $display("%0t: computed_crc expected %h actual %h",
                             $time, want_result.computed_crc, result.computed_crc);
                    fail_count++;
                end
                if (result.received_crc !== want_result.received_crc)
                begin
                    $display("%0t: received_crc expected %h actual %h",
                             $time, want_result.received_crc, result.received_crc);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (bursty && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    task automatic send_beat(input logic [7:0] b, input logic last);
        if (bursty && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        item       <= '{text_byte: b, is_last: last};
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        beats_sent++;
    endtask

    task automatic send_payload();
        int n;
        for (n = 0; n < payload_bytes.size(); n++)
        begin
            send_beat(payload_bytes[n], n == payload_bytes.size() - 1);
        end
        payload_bytes.delete();
    endtask

    function automatic void add_text(input string s);
        int n;
        for (n = 0; n < s.len(); n++)
        begin
            payload_bytes.push_back(s[n]);
        end
    endfunction

    function automatic string hex_text(input logic [27:0] v, input int digits, input bit upper);
        string      s;
        string      glyphs;
        int         n;
        logic [3:0] nib;
        glyphs = upper ? "0123456789ABCDEF" : "0123456789abcdef";
        s = "";
        for (n = digits - 1; n >= 0; n--)
        begin
            nib = v[n*4 +: 4];
            s = {s, glyphs.substr(nib, nib)};
        end
        return s;
    endfunction

    function automatic void load_object(input string s);
        int n;
        object_bytes.delete();
        for (n = 0; n < s.len(); n++)
        begin
            object_bytes.push_back(s[n]);
        end
    endfunction

    function automatic logic [15:0] object_crc();
        logic [15:0] acc;
        acc = MODBUS_SEED;
        foreach (object_bytes[n])
        begin
            acc = modbus_update(acc, object_bytes[n]);
        end
        return acc;
    endfunction

    function automatic void add_data_field(input int spaces);
        add_text(data_tag);
        repeat (spaces) payload_bytes.push_back(ASCII_SPACE);
        foreach (object_bytes[n])
        begin
            payload_bytes.push_back(object_bytes[n]);
        end
    endfunction

    function automatic void add_crc_field(input string body, input int spaces);
        add_text(crc_tag);
        repeat (spaces) payload_bytes.push_back(ASCII_SPACE);
        payload_bytes.push_back(ASCII_QUOTE);
        add_text(body);
        payload_bytes.push_back(ASCII_QUOTE);
    endfunction

    function automatic void random_object(input int span);
        int         lvl;
        int         n;
        logic [7:0] ch;
        object_bytes.delete();
        object_bytes.push_back(ASCII_LBRACE);
        lvl = 1;
        for (n = 0; n < span; n++)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    if (lvl < 4)
                    begin
                        object_bytes.push_back(ASCII_LBRACE);
                        lvl++;
                    end
                end
                1:
                begin
                    if (lvl > 1)
                    begin
                        object_bytes.push_back(ASCII_RBRACE);
                        lvl--;
                    end
                end
                2:
                begin
                    ch = 8'($urandom_range(0, 255));
                    if (ch == ASCII_LBRACE || ch == ASCII_RBRACE)
                    begin
                        ch = ASCII_TILDE;
                    end
                    object_bytes.push_back(ch);
                end
                default:
                begin
                    object_bytes.push_back(8'($urandom_range(32, 122)));
                end
            endcase
        end
        while (lvl > 0)
        begin
            object_bytes.push_back(ASCII_RBRACE);
            lvl--;
        end
    endfunction

    // mostly well-formed payloads, some cut short or corrupted, some pure noise
    function automatic void random_payload();
        int          flavor;
        int          digits;
        int          cut;
        int          n;
        logic [15:0] sum;
        logic [27:0] shown;
        string       crc_body;
        string       junk;
        flavor = $urandom_range(0, 9);
        if (flavor == 9)
        begin
            n = $urandom_range(1, 30);
            repeat (n) payload_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        random_object($urandom_range(2, 16));
        sum = object_crc();
        digits = ($urandom_range(0, 2) != 0) ? 4 : $urandom_range(1, 7);
        shown = {12'($urandom), sum};
        if ($urandom_range(0, 3) == 0)
        begin
            shown[15:0] = 16'($urandom);
        end
        crc_body = hex_text(shown, digits, $urandom_range(0, 1));
        if (digits < 7 && $urandom_range(0, 4) == 0)
        begin
            junk = " gx-+";
            n = $urandom_range(0, 4);
            crc_body = {crc_body, junk.substr(n, n)};
        end
        if ($urandom_range(0, 1))
        begin
            add_text("{");
        end
        if ($urandom_range(0, 1))
        begin
            add_crc_field(crc_body, $urandom_range(0, 2));
            add_text(", ");
            add_data_field($urandom_range(0, 2));
        end
        else
        begin
            add_data_field($urandom_range(0, 2));
            add_text(",\"id\":5,");
            add_crc_field(crc_body, $urandom_range(0, 2));
        end
        if ($urandom_range(0, 1))
        begin
            add_text("}");
        end
        if (flavor >= 7)
        begin
            if ($urandom_range(0, 1))
            begin
                cut = $urandom_range(1, payload_bytes.size());
                while (payload_bytes.size() > cut)
                begin
                    void'(payload_bytes.pop_back());
                end
            end
            else
            begin
                payload_bytes[$urandom_range(0, payload_bytes.size() - 1)] =
                    8'($urandom_range(0, 255));
            end
        end
    endfunction

    task automatic test_verdicts();
        logic [15:0] sum;
        load_object("{\"v\":1}");
        sum = object_crc();
        add_text("{");
        add_crc_field(hex_text(28'(sum), 4, 1'b1), 1);
        add_text(",");
        add_data_field(1);
        add_text("}");
        send_payload();

        load_object("{\"a\":[1,2]}");
        sum = object_crc();
        add_text("{");
        add_data_field(0);
        add_text(",");
        add_crc_field(hex_text(28'(sum), 4, 1'b0), 0);
        add_text("}");
        send_payload();

        add_crc_field(hex_text(28'(sum + 16'd1), 4, 1'b1), 0);
        add_data_field(0);
        send_payload();
    endtask

    task automatic test_crc_field();
        load_object("{}");
        add_data_field(0);
        send_payload();

        add_crc_field("", 0);
        add_data_field(0);
        send_payload();

        add_crc_field("12345678", 0);
        add_data_field(0);
        send_payload();

        add_text("\"CRC\": 1234,");
        add_data_field(0);
        send_payload();

        add_data_field(0);
        add_text(",\"CRC\":\"12");
        send_payload();

        // good crc field with an unterminated object gives a bad object verdict
        add_crc_field("1", 2);
        add_text(",\"DATA\":{\"x\"");
        send_payload();

        add_text("xyz");
        send_payload();
    endtask

    task automatic test_hex_forms();
        load_object("{}");
        add_crc_field(" 1A", 0);
        add_data_field(0);
        send_payload();

        add_crc_field("0x1A", 0);
        add_data_field(0);
        send_payload();

        add_crc_field("-1A", 0);
        add_data_field(0);
        send_payload();

        add_crc_field("abcdEF1", 0);
        add_data_field(0);
        send_payload();

        add_text("\"CRC\":\"4");
        payload_bytes.push_back(8'h00);
        add_text("B\"");
        add_data_field(0);
        send_payload();
    endtask

    task automatic test_data_object();
        logic [15:0] sum;
        add_crc_field("0", 0);
        add_text("\"DATA\": [1]");
        send_payload();

        load_object("{{\"a\":{}},\"b\"}");
        add_crc_field("0", 0);
        add_data_field(3);
        send_payload();

        // only the first DATA key counts
        load_object("{1}");
        sum = object_crc();
        add_crc_field(hex_text(28'(sum), 4, 1'b1), 0);
        add_data_field(0);
        add_text(",\"DATA\":{2}");
        send_payload();

        add_text("\"DATA\":{\"CRC\":\"AB\"},\"CRC\":\"CD\"");
        send_payload();

        load_object("{}");
        sum = object_crc();
        add_text("\"DATA\"=1,");
        add_data_field(0);
        add_crc_field(hex_text(28'(sum), 4, 1'b0), 0);
        send_payload();
    endtask

    task automatic test_key_overlap();
        logic [15:0] sum;
        load_object("{7}");
        sum = object_crc();
        add_text("\"CR\"");
        add_crc_field(hex_text(28'(sum), 4, 1'b1), 0);
        add_text(",\"DAT\"");
        add_data_field(0);
        send_payload();
    endtask

    task automatic test_long_object();
        int          k;
        int          span;
        logic [15:0] sum;
        for (k = 0; k < 2; k++)
        begin
            span = (k == 0) ? OBJ_MAX - 1 : OBJ_MAX;
            object_bytes.delete();
            object_bytes.push_back(ASCII_LBRACE);
            repeat (span - 2) object_bytes.push_back(8'h61);
            object_bytes.push_back(ASCII_RBRACE);
            sum = object_crc();
            add_data_field(0);
            add_crc_field(hex_text(28'(sum), 4, 1'b1), 0);
            send_payload();
        end
    endtask

    task automatic test_byte_extremes();
        logic [15:0] sum;
        payload_bytes.push_back(8'h00);
        send_payload();

        payload_bytes.push_back(8'hFF);
        send_payload();

        load_object("{");
        object_bytes.push_back(8'h80);
        object_bytes.push_back(8'hFF);
        object_bytes.push_back(8'h00);
        object_bytes.push_back(8'h01);
        object_bytes.push_back(8'h7F);
        object_bytes.push_back(ASCII_RBRACE);
        sum = object_crc();
        add_crc_field(hex_text(28'(sum), 4, 1'b0), 1);
        add_data_field(2);
        send_payload();
    endtask

    task automatic test_random_payloads();
        while (beats_sent < TOTAL_BEATS)
        begin
            if (beats_sent >= TOTAL_BEATS - CALM_BEATS)
            begin
                bursty = 1'b0;
            end
            random_payload();
            send_payload();
        end
    endtask

    initial
    begin
        clear_parser();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_verdicts();
        test_crc_field();
        test_hex_forms();
        test_data_object();
        test_key_overlap();
        test_long_object();
        test_byte_extremes();
        test_random_payloads();

        item_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
